/* hdl/sdlt_pkg.sv */
// Shared types, constants and hash functions for the socket demux lookup table.
// No dependencies; every other file in hdl/ but sdlt_ram.sv imports this package.
package sdlt_pkg;

    // Table sizes
    localparam int CONN_ENTRIES   = 64;
    localparam int LISTEN_ENTRIES = 16;

    localparam int CONN_IDX_W = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
    localparam int LSN_IDX_W  = (LISTEN_ENTRIES > 1) ? $clog2(LISTEN_ENTRIES) : 1;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int OUTC_W  = 3;
    localparam int OWNER_W = 32;
    localparam int PORT_W  = 16;
    localparam int ADDR_W  = 32;
    localparam int KEY_W   = PORT_W + ADDR_W + PORT_W;

    localparam int CONN_RAM_W = KEY_W + OWNER_W;
    localparam int LSN_RAM_W  = PORT_W + OWNER_W;

    // Last entry of each table, for probe wrap and exhaustion
    localparam logic [CONN_IDX_W-1:0] CONN_LAST = CONN_IDX_W'(CONN_ENTRIES - 1);
    localparam logic [LSN_IDX_W-1:0]  LSN_LAST  = LSN_IDX_W'(LISTEN_ENTRIES - 1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOOKUP   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REG_LSN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REG_CONN = 2'd2;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUT_CONN_HIT   = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_LISTEN_HIT = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_MISS       = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_REGISTERED = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_FULL       = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONN_CHK,
        ST_CONN_CMP,
        ST_LSN_CHK,
        ST_LSN_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OUTC_W-1:0]  outcome;
        logic [OWNER_W-1:0] owner;
    } result_t;

    typedef struct packed {
        logic                  we;
        logic [CONN_IDX_W-1:0] waddr;
        logic [CONN_RAM_W-1:0] wdata;
        logic                  re;
        logic [CONN_IDX_W-1:0] raddr;
    } conn_ram_req_t;

    typedef struct packed {
        logic                 we;
        logic [LSN_IDX_W-1:0] waddr;
        logic [LSN_RAM_W-1:0] wdata;
        logic                 re;
        logic [LSN_IDX_W-1:0] raddr;
    } lsn_ram_req_t;

    // Fold the connection key into a start slot, then bring it below the depth
    function automatic logic [CONN_IDX_W-1:0] conn_hash(input logic [KEY_W-1:0] key);
        logic [CONN_IDX_W-1:0] h;
        logic [CONN_IDX_W:0]   wide;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % CONN_IDX_W] = h[i % CONN_IDX_W] ^ key[i];
        end
        wide = {1'b0, h};
        if (wide >= (CONN_IDX_W + 1)'(CONN_ENTRIES)) begin
            wide = wide - (CONN_IDX_W + 1)'(CONN_ENTRIES);
        end
        return wide[CONN_IDX_W-1:0];
    endfunction

    // Fold the local port into a start slot of the listen table
    function automatic logic [LSN_IDX_W-1:0] lsn_hash(input logic [PORT_W-1:0] port);
        logic [LSN_IDX_W-1:0] h;
        logic [LSN_IDX_W:0]   wide;
        h = '0;
        for (int i = 0; i < PORT_W; i++) begin
            h[i % LSN_IDX_W] = h[i % LSN_IDX_W] ^ port[i];
        end
        wide = {1'b0, h};
        if (wide >= (LSN_IDX_W + 1)'(LISTEN_ENTRIES)) begin
            wide = wide - (LSN_IDX_W + 1)'(LISTEN_ENTRIES);
        end
        return wide[LSN_IDX_W-1:0];
    endfunction

endpackage

/* hdl/socket_demux_lookup_table.sv */
// Socket demux lookup table: connection table with listen-table fallback.
// Each probe that meets a valid slot reads the entry from the table RAM, whose read
// is registered, then compares it. One request at a time; the next beat is taken
// the cycle after the result moves into the output register.
// Reset: asynchronous, active low; clears all valid bits at once, no clearing pass.
module socket_demux_lookup_table
    import sdlt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: owner_in[31:0], local_port[47:32], remote_addr[79:48], remote_port[95:80]
    input  logic [95:0]        s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [REQ_W-1:0]   s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // tdata: owner_out[31:0]
    output logic [OWNER_W-1:0] m_axis_tdata,
    // tuser: outcome[2:0]
    output logic [OUTC_W-1:0]  m_axis_tuser
);

    conn_ram_req_t         conn_ram;
    lsn_ram_req_t          lsn_ram;
    logic [CONN_RAM_W-1:0] conn_rdata;
    logic [LSN_RAM_W-1:0]  lsn_rdata;
    logic                  res_valid;
    logic                  res_ready;
    result_t               res;

    // Connection keys and owners
    sdlt_ram #(
        .WIDTH (CONN_RAM_W),
        .DEPTH (CONN_ENTRIES)
    ) u_conn_ram (
        .clk   (clk),
        .we    (conn_ram.we),
        .waddr (conn_ram.waddr),
        .wdata (conn_ram.wdata),
        .re    (conn_ram.re),
        .raddr (conn_ram.raddr),
        .rdata (conn_rdata)
    );

    // Listen ports and owners
    sdlt_ram #(
        .WIDTH (LSN_RAM_W),
        .DEPTH (LISTEN_ENTRIES)
    ) u_lsn_ram (
        .clk   (clk),
        .we    (lsn_ram.we),
        .waddr (lsn_ram.waddr),
        .wdata (lsn_ram.wdata),
        .re    (lsn_ram.re),
        .raddr (lsn_ram.raddr),
        .rdata (lsn_rdata)
    );

    sdlt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (s_axis_tuser),
        .in_owner   (s_axis_tdata[31:0]),
        .in_lport   (s_axis_tdata[47:32]),
        .in_raddr   (s_axis_tdata[79:48]),
        .in_rport   (s_axis_tdata[95:80]),
        .conn_ram   (conn_ram),
        .conn_rdata (conn_rdata),
        .lsn_ram    (lsn_ram),
        .lsn_rdata  (lsn_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    sdlt_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* hdl/sdlt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sdlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/sdlt_ctrl.sv */
// Request sequencer: linear-probe search, insert and update over both tables.
// Holds the valid bits; keys and owners live in the two sdlt_ram instances. Uses sdlt_pkg.
module sdlt_ctrl
    import sdlt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      in_req,
    input  logic [OWNER_W-1:0]    in_owner,
    input  logic [PORT_W-1:0]     in_lport,
    input  logic [ADDR_W-1:0]     in_raddr,
    input  logic [PORT_W-1:0]     in_rport,
    output conn_ram_req_t         conn_ram,
    input  logic [CONN_RAM_W-1:0] conn_rdata,
    output lsn_ram_req_t          lsn_ram,
    input  logic [LSN_RAM_W-1:0]  lsn_rdata,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res
);

    state_t                state_reg, state_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [OWNER_W-1:0]    owner_reg, owner_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [CONN_IDX_W-1:0] cidx_reg, cidx_next;
    logic [CONN_IDX_W-1:0] ccnt_reg, ccnt_next;
    logic [LSN_IDX_W-1:0]  lidx_reg, lidx_next;
    logic [LSN_IDX_W-1:0]  lcnt_reg, lcnt_next;
    result_t               res_reg, res_next;

    logic                  conn_valid_reg [CONN_ENTRIES];
    logic                  lsn_valid_reg [LISTEN_ENTRIES];
    logic                  conn_set;
    logic                  lsn_set;
    logic [KEY_W-1:0]      in_key;
    logic [CONN_IDX_W-1:0] cidx_adv;
    logic [LSN_IDX_W-1:0]  lidx_adv;

    assign in_key   = {in_lport, in_raddr, in_rport};
    assign cidx_adv = (cidx_reg == CONN_LAST) ? '0 : cidx_reg + 1'b1;
    assign lidx_adv = (lidx_reg == LSN_LAST) ? '0 : lidx_reg + 1'b1;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Valid bits: clear at reset, set on insert
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CONN_ENTRIES; i++)
            begin
                conn_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < LISTEN_ENTRIES; i++)
            begin
                lsn_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (conn_set)
            begin
                conn_valid_reg[cidx_reg] <= 1'b1;
            end
            if (lsn_set)
            begin
                lsn_valid_reg[lidx_reg] <= 1'b1;
            end
        end
    end

    // Request payload and probe pointers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        owner_reg <= owner_next;
        key_reg   <= key_next;
        cidx_reg  <= cidx_next;
        ccnt_reg  <= ccnt_next;
        lidx_reg  <= lidx_next;
        lcnt_reg  <= lcnt_next;
        res_reg   <= res_next;
    end

    // Next state, memory requests and result
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        owner_next = owner_reg;
        key_next   = key_reg;
        cidx_next  = cidx_reg;
        ccnt_next  = ccnt_reg;
        lidx_next  = lidx_reg;
        lcnt_next  = lcnt_reg;
        res_next   = res_reg;
        conn_set   = 1'b0;
        lsn_set    = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        conn_ram.we    = 1'b0;
        conn_ram.re    = 1'b0;
        conn_ram.waddr = cidx_reg;
        conn_ram.raddr = cidx_reg;
        conn_ram.wdata = {key_reg, owner_reg};
        lsn_ram.we     = 1'b0;
        lsn_ram.re     = 1'b0;
        lsn_ram.waddr  = lidx_reg;
        lsn_ram.raddr  = lidx_reg;
        lsn_ram.wdata  = {key_reg[KEY_W-1 -: PORT_W], owner_reg};

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next         = in_req;
                    owner_next       = in_owner;
                    key_next         = in_key;
                    cidx_next        = conn_hash(in_key);
                    lidx_next        = lsn_hash(in_lport);
                    ccnt_next        = '0;
                    lcnt_next        = '0;
                    res_next.outcome = OUT_MISS;
                    res_next.owner   = '0;
                    if (in_req == REQ_LOOKUP || in_req == REQ_REG_CONN)
                    begin
                        state_next = ST_CONN_CHK;
                    end
                    else if (in_req == REQ_REG_LSN)
                    begin
                        state_next = ST_LSN_CHK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            // Empty slot ends the probe; otherwise fetch the entry
            ST_CONN_CHK:
            begin
                if (!conn_valid_reg[cidx_reg])
                begin
                    if (req_reg == REQ_REG_CONN)
                    begin
                        conn_ram.we      = 1'b1;
                        conn_set         = 1'b1;
                        res_next.outcome = OUT_REGISTERED;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LSN_CHK;
                    end
                end
                else
                begin
                    conn_ram.re = 1'b1;
                    state_next  = ST_CONN_CMP;
                end
            end

            ST_CONN_CMP:
            begin
                if (conn_rdata[CONN_RAM_W-1 -: KEY_W] == key_reg)
                begin
                    if (req_reg == REQ_REG_CONN)
                    begin
                        conn_ram.we      = 1'b1;
                        res_next.outcome = OUT_REGISTERED;
                    end
                    else
                    begin
                        res_next.outcome = OUT_CONN_HIT;
                        res_next.owner   = conn_rdata[OWNER_W-1:0];
                    end
                    state_next = ST_DONE;
                end
                else if (ccnt_reg == CONN_LAST)
                begin
                    // Every slot probed without a match
                    if (req_reg == REQ_REG_CONN)
                    begin
                        res_next.outcome = OUT_FULL;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LSN_CHK;
                    end
                end
                else
                begin
                    cidx_next  = cidx_adv;
                    ccnt_next  = ccnt_reg + 1'b1;
                    state_next = ST_CONN_CHK;
                end
            end

            ST_LSN_CHK:
            begin
                if (!lsn_valid_reg[lidx_reg])
                begin
                    if (req_reg == REQ_REG_LSN)
                    begin
                        lsn_ram.we       = 1'b1;
                        lsn_set          = 1'b1;
                        res_next.outcome = OUT_REGISTERED;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    lsn_ram.re = 1'b1;
                    state_next = ST_LSN_CMP;
                end
            end

            ST_LSN_CMP:
            begin
                if (lsn_rdata[LSN_RAM_W-1 -: PORT_W] == key_reg[KEY_W-1 -: PORT_W])
                begin
                    if (req_reg == REQ_REG_LSN)
                    begin
                        lsn_ram.we       = 1'b1;
                        res_next.outcome = OUT_REGISTERED;
                    end
                    else
                    begin
                        res_next.outcome = OUT_LISTEN_HIT;
                        res_next.owner   = lsn_rdata[OWNER_W-1:0];
                    end
                    state_next = ST_DONE;
                end
                else if (lcnt_reg == LSN_LAST)
                begin
                    if (req_reg == REQ_REG_LSN)
                    begin
                        res_next.outcome = OUT_FULL;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    lidx_next  = lidx_adv;
                    lcnt_next  = lcnt_reg + 1'b1;
                    state_next = ST_LSN_CHK;
                end
            end

            // Hold the result until the output stage takes it
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // Any table write finishes the request
    a_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (conn_ram.we || lsn_ram.we) |=> state_reg == ST_DONE)
        else $error("table write did not finish the request");

    // An accepted beat starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != ST_IDLE)
        else $error("accepted beat left the sequencer idle");

    // An insert marks its slot valid
    a_conn_insert: assert property (@(posedge clk) disable iff (!rst_n)
        conn_set |=> conn_valid_reg[$past(cidx_reg)])
        else $error("connection insert did not set its valid bit");

    // Registered and full answer only register requests
    a_reg_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.outcome == OUT_REGISTERED || res.outcome == OUT_FULL))
            |-> (req_reg == REQ_REG_LSN || req_reg == REQ_REG_CONN))
        else $error("register outcome on a non-register request");

endmodule

/* hdl/sdlt_out.sv */
// Output register for result beats, so the sequencer can take the next request.
// Uses sdlt_pkg for the result type.
module sdlt_out
    import sdlt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    output logic                res_ready,
    input  result_t             res,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUTC_W-1:0]   m_axis_tuser,
    output logic [OWNER_W-1:0]  m_axis_tdata
);

    logic    tvalid_reg, tvalid_next;
    result_t data_reg;

    assign res_ready = !tvalid_reg || m_axis_tready;

    always_comb
    begin
        tvalid_next = tvalid_reg;
        if (res_ready)
        begin
            tvalid_next = res_valid;
        end
    end

    // Hold valid until the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
        end
    end

    // Load the payload when the slot frees
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tuser  = data_reg.outcome;
    assign m_axis_tdata  = data_reg.owner;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for socket_demux_lookup_table: streams lookup and register
// beats, predicts every reply from its own copy of both tables. Depends on sdlt_pkg.
module testbench;
    import sdlt_pkg::*;

    // Request code the block treats as a no-op
    localparam logic [REQ_W-1:0] REQ_UNDEFINED = 2'd3;

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int LPORT_POOL    = 10;
    localparam int RADDR_POOL    = 4;
    localparam int RPORT_POOL    = 4;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int FULL_MIX_ITEMS = 300;

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [OWNER_W-1:0] owner;
        logic [PORT_W-1:0]  lport;
        logic [ADDR_W-1:0]  raddr;
        logic [PORT_W-1:0]  rport;
    } sock_req_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // tdata: owner_in[31:0], local_port[47:32], remote_addr[79:48], remote_port[95:80]
    logic [95:0]        s_axis_tdata;
    // tuser: req_type[1:0]
    logic [REQ_W-1:0]   s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // tdata: owner_out[31:0]
    logic [OWNER_W-1:0] m_axis_tdata;
    // tuser: outcome[2:0]
    logic [OUTC_W-1:0]  m_axis_tuser;

    // Shadow copy of both tables
    logic               conn_live   [CONN_ENTRIES];
    logic [KEY_W-1:0]   conn_key    [CONN_ENTRIES];
    logic [OWNER_W-1:0] conn_owner  [CONN_ENTRIES];
    logic               lsn_live    [LISTEN_ENTRIES];
    logic [PORT_W-1:0]  lsn_port    [LISTEN_ENTRIES];
    logic [OWNER_W-1:0] lsn_owner   [LISTEN_ENTRIES];
    int                 conn_count;
    int                 lsn_count;

    // Key pools that keep random traffic hitting existing entries
    logic [PORT_W-1:0]  lport_pool [LPORT_POOL];
    logic [ADDR_W-1:0]  raddr_pool [RADDR_POOL];
    logic [PORT_W-1:0]  rport_pool [RPORT_POOL];

    result_t            pending_replies[$];
    int                 src_gap_max;
    int                 sink_stall_max;
    int                 n_errors;
    int                 n_replies;
    int                 n_requests;
    int                 outcome_tally [8];
    longint             cycle_count;

    socket_demux_lookup_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d replies pending",
                     cycle_count, pending_replies.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Work out the reply and update the shadow tables
    function automatic result_t predict_demux(input sock_req_t r);
        result_t          res;
        logic [KEY_W-1:0] key;
        int               ci;
        int               li;
        key = {r.lport, r.raddr, r.rport};
        res.outcome = OUT_MISS;
        res.owner = '0;
        ci = -1;
        li = -1;
        for (int i = 0; i < CONN_ENTRIES; i++)
            if (ci < 0 && conn_live[i] && conn_key[i] == key)
                ci = i;
        for (int i = 0; i < LISTEN_ENTRIES; i++)
            if (li < 0 && lsn_live[i] && lsn_port[i] == r.lport)
                li = i;
        case (r.kind)
            REQ_LOOKUP:
            begin
                if (ci >= 0)
                begin
                    res.outcome = OUT_CONN_HIT;
                    res.owner = conn_owner[ci];
                end
                else if (li >= 0)
                begin
                    res.outcome = OUT_LISTEN_HIT;
                    res.owner = lsn_owner[li];
                end
            end
            REQ_REG_LSN:
            begin
                // New port takes the lowest free entry
                for (int i = 0; i < LISTEN_ENTRIES; i++)
                    if (li < 0 && !lsn_live[i])
                        li = i;
                if (li >= 0)
                begin
                    if (!lsn_live[li])
                        lsn_count++;
                    lsn_live[li] = 1'b1;
                    lsn_port[li] = r.lport;
                    lsn_owner[li] = r.owner;
                    res.outcome = OUT_REGISTERED;
                end
                else
                    res.outcome = OUT_FULL;
            end
            REQ_REG_CONN:
            begin
                for (int i = 0; i < CONN_ENTRIES; i++)
                    if (ci < 0 && !conn_live[i])
                        ci = i;
                if (ci >= 0)
                begin
                    if (!conn_live[ci])
                        conn_count++;
                    conn_live[ci] = 1'b1;
                    conn_key[ci] = key;
                    conn_owner[ci] = r.owner;
                    res.outcome = OUT_REGISTERED;
                end
                else
                    res.outcome = OUT_FULL;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic sock_req_t make_req(input logic [REQ_W-1:0] kind,
                                           input logic [OWNER_W-1:0] owner,
                                           input logic [PORT_W-1:0] lport,
                                           input logic [ADDR_W-1:0] raddr,
                                           input logic [PORT_W-1:0] rport);
        sock_req_t r;
        r.kind = kind;
        r.owner = owner;
        r.lport = lport;
        r.raddr = raddr;
        r.rport = rport;
        return r;
    endfunction

    // Send one request beat after a random gap; tvalid stays high on a zero gap
    task automatic send_request(input sock_req_t r);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {r.rport, r.raddr, r.lport, r.owner};
        s_axis_tuser  <= r.kind;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_replies.push_back(predict_demux(r));
        n_requests++;
    endtask

    task automatic report_mismatch(input string what, input logic [OWNER_W-1:0] got,
                                   input logic [OWNER_W-1:0] want);
        $display("ERROR t=%0t reply %0d: %s got %0h expected %0h",
                 $time, n_replies, what, got, want);
        n_errors++;
    endtask

    // Reply side: stall a random number of cycles before each beat
    initial
    begin : reply_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = $urandom_range(0, sink_stall_max);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare each reply beat with the oldest prediction
    always @(posedge clk)
    begin : check_replies
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("reply with nothing pending", m_axis_tdata, '0);
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.outcome)
                    report_mismatch("outcome", OWNER_W'(m_axis_tuser), OWNER_W'(want.outcome));
                if (m_axis_tdata !== want.owner)
                    report_mismatch("owner", m_axis_tdata, want.owner);
            end
            if (!$isunknown(m_axis_tuser))
                outcome_tally[m_axis_tuser]++;
            n_replies++;
        end
    end

    // Field extremes, replacement, fallback, owner zero, undefined code
    task automatic test_directed_cases();
        src_gap_max = 10;
        sink_stall_max = 10;
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h0, 32'h0, 16'h0));
        send_request(make_req(REQ_LOOKUP, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
        send_request(make_req(REQ_UNDEFINED, 32'h0, 16'h0, 32'h0, 16'h0));
        send_request(make_req(REQ_REG_LSN, 32'h0, 16'h0, 32'hFFFFFFFF, 16'hFFFF));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h0, $urandom, 16'h1234));
        send_request(make_req(REQ_REG_LSN, 32'hFFFFFFFF, 16'hFFFF, 32'h0, 16'h0));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
        send_request(make_req(REQ_REG_CONN, 32'h0, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
        send_request(make_req(REQ_REG_CONN, 32'h12345678, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFE));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'hFFFF, 32'hFFFFFFFE, 16'hFFFF));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h1234, 32'h0, 16'h0));
        send_request(make_req(REQ_REG_CONN, 32'hA5A5A5A5, 16'h0, 32'h0, 16'h0));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h0, 32'h0, 16'h0));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h0, 32'h0, 16'h1));
        send_request(make_req(REQ_REG_LSN, 32'h5A5A5A5A, 16'h0, 32'h0, 16'h0));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h0, 32'h0, 16'h1));
        send_request(make_req(REQ_UNDEFINED, 32'hFFFFFFFF, 16'h0, 32'h0, 16'h0));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h0, 32'h0, 16'h0));
        send_request(make_req(REQ_REG_CONN, 32'h7, 16'h1234, 32'hC0A80001, 16'd80));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h1234, 32'hC0A80001, 16'd80));
        send_request(make_req(REQ_LOOKUP, 32'h0, 16'h1234, 32'hC0A80001, 16'd81));
    endtask

    // Random traffic, mostly on pooled keys; idling pattern changes every 100 beats
    task automatic send_random_mix(input int n_items);
        sock_req_t r;
        int        roll;
        for (int k = 0; k < n_items; k++)
        begin
            case ((k / 100) % 4)
                0: begin src_gap_max = 10; sink_stall_max = 10; end
                1: begin src_gap_max = 0;  sink_stall_max = 0;  end
                2: begin src_gap_max = 0;  sink_stall_max = 10; end
                default: begin src_gap_max = 10; sink_stall_max = 0; end
            endcase
            roll = $urandom_range(0, 99);
            r.owner = $urandom;
            r.lport = lport_pool[$urandom_range(0, LPORT_POOL - 1)];
            r.raddr = raddr_pool[$urandom_range(0, RADDR_POOL - 1)];
            r.rport = rport_pool[$urandom_range(0, RPORT_POOL - 1)];
            if (roll < 45)
                r.kind = REQ_LOOKUP;
            else if (roll < 60)
                r.kind = REQ_REG_CONN;
            else if (roll < 68)
            begin
                // Remote fields are don't-care for a listener
                r.kind = REQ_REG_LSN;
                r.raddr = $urandom;
                r.rport = PORT_W'($urandom);
            end
            else
            begin
                // Noise: undefined codes and lookups on arbitrary keys
                r.kind = (roll < 75) ? REQ_UNDEFINED : REQ_LOOKUP;
                r.raddr = $urandom;
                r.rport = PORT_W'($urandom);
                if (roll < 88)
                    r.lport = PORT_W'($urandom);
            end
            send_request(r);
        end
    endtask

    task automatic test_random_traffic();
        lport_pool[0] = 16'h0;
        lport_pool[1] = 16'hFFFF;
        for (int i = 2; i < LPORT_POOL; i++)
            lport_pool[i] = PORT_W'($urandom);
        raddr_pool[0] = 32'h0;
        raddr_pool[1] = 32'hFFFFFFFF;
        rport_pool[0] = 16'h0;
        rport_pool[1] = 16'hFFFF;
        for (int i = 2; i < RADDR_POOL; i++)
            raddr_pool[i] = $urandom;
        for (int i = 2; i < RPORT_POOL; i++)
            rport_pool[i] = PORT_W'($urandom);
        send_random_mix(RANDOM_ITEMS);
    endtask

    // Fill both tables, overflow them, replace owners in full tables, then mix
    task automatic test_full_tables();
        int idx;
        src_gap_max = 10;
        sink_stall_max = 10;
        while (lsn_count < LISTEN_ENTRIES)
            send_request(make_req(REQ_REG_LSN, $urandom, PORT_W'($urandom), $urandom,
                                  PORT_W'($urandom)));
        repeat (3)
            send_request(make_req(REQ_REG_LSN, $urandom, PORT_W'($urandom), $urandom,
                                  PORT_W'($urandom)));
        idx = $urandom_range(0, LISTEN_ENTRIES - 1);
        send_request(make_req(REQ_REG_LSN, $urandom, lsn_port[idx], $urandom,
                              PORT_W'($urandom)));
        send_request(make_req(REQ_LOOKUP, $urandom, lsn_port[idx], $urandom,
                              PORT_W'($urandom)));
        while (conn_count < CONN_ENTRIES)
            send_request(make_req(REQ_REG_CONN, $urandom, PORT_W'($urandom), $urandom,
                                  PORT_W'($urandom)));
        repeat (3)
            send_request(make_req(REQ_REG_CONN, $urandom, PORT_W'($urandom), $urandom,
                                  PORT_W'($urandom)));
        idx = $urandom_range(0, CONN_ENTRIES - 1);
        send_request(make_req(REQ_REG_CONN, $urandom, conn_key[idx][63:48],
                              conn_key[idx][47:16], conn_key[idx][15:0]));
        send_request(make_req(REQ_LOOKUP, $urandom, conn_key[idx][63:48],
                              conn_key[idx][47:16], conn_key[idx][15:0]));
        send_random_mix(FULL_MIX_ITEMS);
    endtask

    initial
    begin
        for (int i = 0; i < CONN_ENTRIES; i++)
            conn_live[i] = 1'b0;
        for (int i = 0; i < LISTEN_ENTRIES; i++)
            lsn_live[i] = 1'b0;
        conn_count = 0;
        lsn_count = 0;
        n_errors = 0;
        n_replies = 0;
        n_requests = 0;
        cycle_count = 0;
        src_gap_max = 10;
        sink_stall_max = 10;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_LOOKUP;

        // Hold reset, then release it on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_full_tables();

        // Drop valid, drain, then watch for stray replies
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, got %0d replies; %0d errors", n_requests, n_replies,
                 n_errors);
        $display("conn hits %0d, listener hits %0d, misses %0d, registered %0d, full %0d",
                 outcome_tally[OUT_CONN_HIT], outcome_tally[OUT_LISTEN_HIT],
                 outcome_tally[OUT_MISS], outcome_tally[OUT_REGISTERED],
                 outcome_tally[OUT_FULL]);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
